// ----- rtl/core/pmsm_pkg.sv -----
`default_nettype none
package pmsm_pkg;

    localparam int unsigned CellW  = 13;
    localparam int unsigned BankW  = 14;
    localparam int unsigned TimeW  = 32;
    localparam int unsigned ModeW  = 3;
    localparam int unsigned CfgIdxW = 2;
    localparam int unsigned CfgDataW = 32;

    // Mode codes
    localparam logic [ModeW-1:0] MODE_INITIAL       = 3'd0;
    localparam logic [ModeW-1:0] MODE_DEPLOY        = 3'd1;
    localparam logic [ModeW-1:0] MODE_HELLO         = 3'd2;
    localparam logic [ModeW-1:0] MODE_IDLE_NO_FLASH = 3'd3;
    localparam logic [ModeW-1:0] MODE_IDLE_FLASH    = 3'd4;
    localparam logic [ModeW-1:0] MODE_LOW_POWER     = 3'd5;

    // Charger meta state codes
    localparam logic [1:0] META_ALL_GOOD   = 2'd0;
    localparam logic [1:0] META_ONE_LI_DN  = 2'd1;
    localparam logic [1:0] META_TWO_LI_DN  = 2'd2;

    // Configuration register indexes
    localparam logic [CfgIdxW-1:0] CFG_FLASH_MIN_BANK = 2'd0;
    localparam logic [CfgIdxW-1:0] CFG_LI_LOW_POWER   = 2'd1;
    localparam logic [CfgIdxW-1:0] CFG_MIN_INITIAL    = 2'd2;
    localparam logic [CfgIdxW-1:0] CFG_MIN_BOOT       = 2'd3;

    // Configuration reset values
    localparam logic [BankW-1:0] RST_FLASH_MIN_BANK = 14'd6600;
    localparam logic [CellW-1:0] RST_LI_LOW_POWER   = 13'd3650;
    localparam logic [TimeW-1:0] RST_MIN_INITIAL    = 32'd1800;
    localparam logic [TimeW-1:0] RST_MIN_BOOT       = 32'd3600;

    // Decision inputs handed from the criteria logic to the mode logic.
    typedef struct packed {
        logic lp_entry;
        logic flash_ok;
        logic below_flash;
        logic past_initial;
        logic past_boot;
        logic may_deploy;
        logic deploy_done;
        logic flash_off;
    } t_crit;

    typedef struct packed {
        logic [ModeW-1:0] next_mode;
        logic             mode_changed;
        logic             suspend_deploy_task;
        logic             bad_mode_error;
    } t_result;

endpackage
`default_nettype wire

// ----- rtl/core/pmsm_crit.sv -----
`default_nettype none
module pmsm_crit
    import pmsm_pkg::*;
(
    input  wire logic [CellW-1:0] i_li_cell1_mv,
    input  wire logic [CellW-1:0] i_li_cell2_mv,
    input  wire logic [CellW-1:0] i_lf_cell1_mv,
    input  wire logic [CellW-1:0] i_lf_cell2_mv,
    input  wire logic [CellW-1:0] i_lf_cell3_mv,
    input  wire logic [CellW-1:0] i_lf_cell4_mv,
    input  wire logic [1:0]       i_bank_full_flags,
    input  wire logic [3:0]       i_retired_flags,
    input  wire logic [1:0]       i_charge_meta_state,
    input  wire logic [2:0]       i_event_flags,
    input  wire logic [TimeW-1:0] i_time_secs,
    input  wire logic [BankW-1:0] i_flash_min_bank_mv,
    input  wire logic [CellW-1:0] i_li_low_power_mv,
    input  wire logic [TimeW-1:0] i_min_initial_secs,
    input  wire logic [TimeW-1:0] i_min_boot_secs,
    output t_crit                 o_crit
);

    logic [BankW-1:0] sum1;
    logic [BankW-1:0] sum2;
    logic             li1_low;
    logic             li2_low;

    assign sum1 = {1'b0, i_lf_cell1_mv} + {1'b0, i_lf_cell2_mv};
    assign sum2 = {1'b0, i_lf_cell3_mv} + {1'b0, i_lf_cell4_mv};

    assign li1_low = i_li_cell1_mv <= i_li_low_power_mv;
    assign li2_low = i_li_cell2_mv <= i_li_low_power_mv;

    always_comb begin
        o_crit.flash_ok =
            (i_bank_full_flags[0] && (sum2 >= i_flash_min_bank_mv || i_retired_flags[3]))
            || (i_bank_full_flags[1] && (sum1 >= i_flash_min_bank_mv || i_retired_flags[2]));
        o_crit.below_flash = (sum1 < i_flash_min_bank_mv) || (sum2 < i_flash_min_bank_mv);
        // With one Li-ion cell down, low power is wanted when every cell still
        // in service reads healthy, since the charger sees a fault it cannot explain.
        o_crit.lp_entry =
            (i_charge_meta_state == META_TWO_LI_DN)
            || (i_charge_meta_state == META_ALL_GOOD && (li1_low || li2_low))
            || (i_charge_meta_state == META_ONE_LI_DN
                && (i_retired_flags[0] || !li1_low)
                && (i_retired_flags[1] || !li2_low));
        o_crit.past_initial = i_time_secs > i_min_initial_secs;
        o_crit.past_boot    = i_time_secs > i_min_boot_secs;
        o_crit.may_deploy   = i_event_flags[0];
        o_crit.deploy_done  = i_event_flags[1];
        o_crit.flash_off    = i_event_flags[2];
    end

endmodule
`default_nettype wire

// ----- rtl/core/pmsm_mode.sv -----
`default_nettype none
module pmsm_mode
    import pmsm_pkg::*;
(
    input  wire logic [ModeW-1:0] i_cur_mode,
    input  wire t_crit            i_crit,
    output t_result               o_result
);

    logic [ModeW-1:0] next;
    logic             suspend;
    logic             err;

    always_comb begin
        next    = i_cur_mode;
        suspend = 1'b0;
        err     = 1'b0;
        unique case (i_cur_mode)
            MODE_INITIAL: begin
                if (i_crit.past_initial && i_crit.may_deploy) next = MODE_DEPLOY;
            end
            MODE_DEPLOY: begin
                if (i_crit.lp_entry) next = MODE_LOW_POWER;
                else if (i_crit.deploy_done) next = MODE_HELLO;
            end
            MODE_HELLO: begin
                if (i_crit.lp_entry) next = MODE_LOW_POWER;
                else if (i_crit.past_boot) next = MODE_IDLE_NO_FLASH;
                else if (i_crit.deploy_done) suspend = 1'b1;
            end
            MODE_IDLE_NO_FLASH: begin
                if (i_crit.lp_entry) next = MODE_LOW_POWER;
                else if (i_crit.flash_ok && !i_crit.flash_off) next = MODE_IDLE_FLASH;
            end
            MODE_IDLE_FLASH: begin
                if (i_crit.lp_entry) next = MODE_LOW_POWER;
                else if (i_crit.below_flash || i_crit.flash_off) next = MODE_IDLE_NO_FLASH;
            end
            MODE_LOW_POWER: begin
                if (!i_crit.lp_entry) begin
                    next = i_crit.past_boot ? MODE_IDLE_NO_FLASH : MODE_DEPLOY;
                end
            end
            default: begin
                next = MODE_IDLE_NO_FLASH;
                err  = 1'b1;
            end
        endcase
    end

    assign o_result.next_mode           = next;
    assign o_result.mode_changed        = next != i_cur_mode;
    assign o_result.suspend_deploy_task = suspend;
    assign o_result.bad_mode_error      = err;

endmodule
`default_nettype wire

// ----- rtl/core/power_mode_state_machine_top.sv -----
// Pipeline: an accepted request is held in the input register, then moves to the
// result register. Throughput: one request per cycle unless the output stalls;
// the mode register is updated as each request moves to the result register.
// Reset (synchronous, active low): mode returns to initial, the configuration
// registers return to their defaults and both pipeline stages empty.
`default_nettype none
module power_mode_state_machine_top
    import pmsm_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_cfg_we,
    input  wire logic [CfgIdxW-1:0]  i_cfg_index,
    input  wire logic [CfgDataW-1:0] i_cfg_data,
    input  wire logic                i_in_valid,
    output logic                     o_in_stall,
    input  wire logic [CellW-1:0]    i_li_cell1_mv,
    input  wire logic [CellW-1:0]    i_li_cell2_mv,
    input  wire logic [CellW-1:0]    i_lf_cell1_mv,
    input  wire logic [CellW-1:0]    i_lf_cell2_mv,
    input  wire logic [CellW-1:0]    i_lf_cell3_mv,
    input  wire logic [CellW-1:0]    i_lf_cell4_mv,
    input  wire logic [1:0]          i_bank_full_flags,
    input  wire logic [3:0]          i_retired_flags,
    input  wire logic [1:0]          i_charge_meta_state,
    input  wire logic [2:0]          i_event_flags,
    input  wire logic [TimeW-1:0]    i_time_secs,
    output logic                     o_out_valid,
    input  wire logic                i_out_stall,
    output logic [ModeW-1:0]         o_next_mode,
    output logic                     o_mode_changed,
    output logic                     o_suspend_deploy_task,
    output logic                     o_bad_mode_error
);

    logic [BankW-1:0] r_flash_min_bank_mv;
    logic [CellW-1:0] r_li_low_power_mv;
    logic [TimeW-1:0] r_min_initial_secs;
    logic [TimeW-1:0] r_min_boot_secs;

    logic             r_in_valid;
    logic [CellW-1:0] r_li_cell1_mv;
    logic [CellW-1:0] r_li_cell2_mv;
    logic [CellW-1:0] r_lf_cell1_mv;
    logic [CellW-1:0] r_lf_cell2_mv;
    logic [CellW-1:0] r_lf_cell3_mv;
    logic [CellW-1:0] r_lf_cell4_mv;
    logic [1:0]       r_bank_full_flags;
    logic [3:0]       r_retired_flags;
    logic [1:0]       r_charge_meta_state;
    logic [2:0]       r_event_flags;
    logic [TimeW-1:0] r_time_secs;

    logic [ModeW-1:0] r_mode;
    logic             r_out_valid;
    t_result          r_result;

    t_crit            crit;
    t_result          n_result;
    logic             out_free;
    logic             advance;
    logic             in_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flash_min_bank_mv <= RST_FLASH_MIN_BANK;
            r_li_low_power_mv   <= RST_LI_LOW_POWER;
            r_min_initial_secs  <= RST_MIN_INITIAL;
            r_min_boot_secs     <= RST_MIN_BOOT;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_FLASH_MIN_BANK: r_flash_min_bank_mv <= i_cfg_data[BankW-1:0];
                CFG_LI_LOW_POWER:   r_li_low_power_mv   <= i_cfg_data[CellW-1:0];
                CFG_MIN_INITIAL:    r_min_initial_secs  <= i_cfg_data[TimeW-1:0];
                CFG_MIN_BOOT:       r_min_boot_secs     <= i_cfg_data[TimeW-1:0];
                default: ;
            endcase
        end
    end

    // The result register is free when empty or being taken this cycle.
    assign out_free   = !r_out_valid || !i_out_stall;
    assign advance    = r_in_valid && out_free;
    assign o_in_stall = r_in_valid && !out_free;
    assign in_take    = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_li_cell1_mv       <= i_li_cell1_mv;
            r_li_cell2_mv       <= i_li_cell2_mv;
            r_lf_cell1_mv       <= i_lf_cell1_mv;
            r_lf_cell2_mv       <= i_lf_cell2_mv;
            r_lf_cell3_mv       <= i_lf_cell3_mv;
            r_lf_cell4_mv       <= i_lf_cell4_mv;
            r_bank_full_flags   <= i_bank_full_flags;
            r_retired_flags     <= i_retired_flags;
            r_charge_meta_state <= i_charge_meta_state;
            r_event_flags       <= i_event_flags;
            r_time_secs         <= i_time_secs;
        end
    end

    pmsm_crit u_crit (
        .i_li_cell1_mv       (r_li_cell1_mv),
        .i_li_cell2_mv       (r_li_cell2_mv),
        .i_lf_cell1_mv       (r_lf_cell1_mv),
        .i_lf_cell2_mv       (r_lf_cell2_mv),
        .i_lf_cell3_mv       (r_lf_cell3_mv),
        .i_lf_cell4_mv       (r_lf_cell4_mv),
        .i_bank_full_flags   (r_bank_full_flags),
        .i_retired_flags     (r_retired_flags),
        .i_charge_meta_state (r_charge_meta_state),
        .i_event_flags       (r_event_flags),
        .i_time_secs         (r_time_secs),
        .i_flash_min_bank_mv (r_flash_min_bank_mv),
        .i_li_low_power_mv   (r_li_low_power_mv),
        .i_min_initial_secs  (r_min_initial_secs),
        .i_min_boot_secs     (r_min_boot_secs),
        .o_crit              (crit)
    );

    pmsm_mode u_mode (
        .i_cur_mode (r_mode),
        .i_crit     (crit),
        .o_result   (n_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= MODE_INITIAL;
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_mode      <= n_result.next_mode;
            r_out_valid <= 1'b1;
        end else if (out_free) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_result <= n_result;
        end
    end

    assign o_out_valid           = r_out_valid;
    assign o_next_mode           = r_result.next_mode;
    assign o_mode_changed        = r_result.mode_changed;
    assign o_suspend_deploy_task = r_result.suspend_deploy_task;
    assign o_bad_mode_error      = r_result.bad_mode_error;

endmodule
`default_nettype wire
